@@ hdl/wtsp_pkg.sv @@
package wtsp_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CAM_X     = 3'd0,
    CFG_CAM_Y     = 3'd1,
    CFG_CAM_Z     = 3'd2,
    CFG_COS_YAW   = 3'd3,
    CFG_SIN_YAW   = 3'd4,
    CFG_COS_PITCH = 3'd5,
    CFG_SIN_PITCH = 3'd6
  } cfg_idx_e;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;
  localparam int CoordW    = 32;   // Q16.16
  localparam int TrigW     = 16;   // Q2.14
  localparam int DiffW     = 33;
  localparam int RotW      = 36;   // yaw stage outputs
  localparam int DepthW    = 39;   // pitch stage outputs
  localparam int SumW      = 40;   // coordinate plus depth
  localparam int DenW      = 40;   // |2z|
  localparam int NumW      = 57;   // |num| + |z|
  localparam int DivSteps  = 32;   // quotient bits
  localparam int RoundBias = 8192;
  localparam int NearLimit = 3276;

  localparam logic signed [CoordW-1:0] CullValue = 32'sd655294464;  // 9999.0
  localparam logic signed [CoordW-1:0] HalfValue = 32'sd32768;      // 0.5
  localparam logic signed [CoordW-1:0] SatMax    = 32'sh7fffffff;
  localparam logic signed [CoordW-1:0] SatMin    = 32'sh80000000;

  typedef struct packed {
    logic signed [CoordW-1:0] cam_x;
    logic signed [CoordW-1:0] cam_y;
    logic signed [CoordW-1:0] cam_z;
    logic signed [TrigW-1:0]  cos_yaw;
    logic signed [TrigW-1:0]  sin_yaw;
    logic signed [TrigW-1:0]  cos_pitch;
    logic signed [TrigW-1:0]  sin_pitch;
  } cfg_t;

  // Classified vertex handed from front to back
  typedef struct packed {
    logic            culled;
    logic            zero_den;
    logic            x_pos;
    logic            x_neg;
    logic            y_pos;
    logic            y_neg;
    logic            neg_x;
    logic            neg_y;
    logic [DenW-1:0] ad;
    logic [NumW-1:0] ax;
    logic [NumW-1:0] ay;
  } proj_t;

endpackage

@@ hdl/wtsp_front.sv @@
module wtsp_front import wtsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output proj_t                    push_data_o
);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  logic signed [DiffW-1:0]  dx_q, dy_q, dz_q, dy2_q, dy3_q;
  logic signed [48:0]       pxc_q, pzs_q, pzc_q, pxs_q;
  logic signed [RotW-1:0]   x3_q, z1_q, x4_q, x5_q;
  logic signed [51:0]       pyc_q, pzs2_q, pys_q, pzc2_q;
  logic signed [DepthW-1:0] y5_q, z5_q;
  proj_t                    out_q, out_d;

  logic signed [49:0]       sx, sz1;
  logic signed [52:0]       sy, sz;
  logic signed [SumW-1:0]   cxz, cyz;
  logic [SumW-1:0]          magx, magy;
  logic [DepthW-1:0]        magz;

  assign en = push_ready_i;
  assign in_ready_o = en;

  always_comb begin
    sx  = 50'(pxc_q) + 50'(pzs_q) + 50'(RoundBias);
    sz1 = 50'(pzc_q) - 50'(pxs_q) + 50'(RoundBias);
    sy  = 53'(pyc_q) - 53'(pzs2_q) + 53'(RoundBias);
    sz  = 53'(pys_q) + 53'(pzc2_q) + 53'(RoundBias);

    cxz  = SumW'(x5_q) + SumW'(z5_q);
    cyz  = SumW'(y5_q) + SumW'(z5_q);
    magx = cxz[SumW-1] ? SumW'(-cxz) : SumW'(cxz);
    magy = cyz[SumW-1] ? SumW'(-cyz) : SumW'(cyz);
    magz = z5_q[DepthW-1] ? DepthW'(-z5_q) : DepthW'(z5_q);

    out_d.culled   = z5_q > DepthW'(NearLimit);
    out_d.zero_den = z5_q == '0;
    out_d.x_pos    = x5_q > 0;
    out_d.x_neg    = x5_q[RotW-1];
    out_d.y_pos    = y5_q > 0;
    out_d.y_neg    = y5_q[DepthW-1];
    out_d.neg_x    = cxz[SumW-1] ^ z5_q[DepthW-1];
    out_d.neg_y    = cyz[SumW-1] ^ z5_q[DepthW-1];
    out_d.ad       = {magz, 1'b0};
    out_d.ax       = NumW'({magx, 16'b0}) + NumW'(magz);
    out_d.ay       = NumW'({magy, 16'b0}) + NumW'(magz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // camera-relative position
      dx_q <= DiffW'(point_x_i) - DiffW'(cfg_i.cam_x);
      dy_q <= DiffW'(point_y_i) - DiffW'(cfg_i.cam_y);
      dz_q <= DiffW'(point_z_i) - DiffW'(cfg_i.cam_z);
      // yaw products
      pxc_q <= dx_q * cfg_i.cos_yaw;
      pzs_q <= dz_q * cfg_i.sin_yaw;
      pzc_q <= dz_q * cfg_i.cos_yaw;
      pxs_q <= dx_q * cfg_i.sin_yaw;
      dy2_q <= dy_q;
      // yaw round
      x3_q  <= RotW'(sx >>> 14);
      z1_q  <= RotW'(sz1 >>> 14);
      dy3_q <= dy2_q;
      // pitch products
      pyc_q  <= dy3_q * cfg_i.cos_pitch;
      pzs2_q <= z1_q * cfg_i.sin_pitch;
      pys_q  <= dy3_q * cfg_i.sin_pitch;
      pzc2_q <= z1_q * cfg_i.cos_pitch;
      x4_q   <= x3_q;
      // pitch round
      y5_q <= DepthW'(sy >>> 14);
      z5_q <= DepthW'(sz >>> 14);
      x5_q <= x4_q;
      // classify
      out_q <= out_d;
    end
  end

  assign push_valid_o = v6_q;
  assign push_data_o  = out_q;

endmodule

@@ hdl/wtsp_fifo.sv @@
module wtsp_fifo import wtsp_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  proj_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output proj_t pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  proj_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("fifo count beyond depth");
  a_last_pop_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push && count_q == CntW'(1)) |=> !pop_valid_o)
    else $error("fifo not empty after last pop");
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && count_q == '0) |=> (pop_valid_o && pop_data_o == $past(push_data_i)))
    else $error("fifo lost item pushed into empty queue");
`endif

endmodule

@@ hdl/wtsp_back.sv @@
module wtsp_back import wtsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pop_valid_i,
  output logic                     pop_ready_o,
  input  proj_t                    pop_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoordW-1:0] screen_x_o,
  output logic signed [CoordW-1:0] screen_y_o,
  output logic                     culled_o
);

  typedef struct packed {
    logic              culled;
    logic              zero_den;
    logic              x_pos;
    logic              x_neg;
    logic              y_pos;
    logic              y_neg;
    logic              neg_x;
    logic              neg_y;
    logic              ovf_x;
    logic              ovf_y;
    logic [DenW-1:0]   ad;
    logic [DenW-1:0]   rx;
    logic [DenW-1:0]   ry;
    logic [CoordW-1:0] lx;
    logic [CoordW-1:0] ly;
    logic [CoordW-1:0] qx;
    logic [CoordW-1:0] qy;
  } div_t;

  logic                     en;
  logic                     vld_q [DivSteps+1];
  div_t                     st_q  [DivSteps+1];
  div_t                     st_d  [DivSteps+1];
  logic                     out_vld_q;
  logic signed [CoordW-1:0] sx_q, sy_q;
  logic                     cull_q;
  div_t                     fin;

  function automatic logic signed [CoordW-1:0] resolve(
    input logic [CoordW-1:0] q,
    input logic              neg,
    input logic              ovf,
    input logic              zero_den,
    input logic              c_pos,
    input logic              c_neg
  );
    logic signed [CoordW-1:0] r;
    if (zero_den) begin
      r = c_pos ? SatMax : (c_neg ? SatMin : HalfValue);
    end else if (ovf) begin
      r = neg ? SatMin : SatMax;
    end else if (neg) begin
      r = (q > {1'b1, {(CoordW-1){1'b0}}}) ? SatMin : CoordW'(-q);
    end else begin
      r = q[CoordW-1] ? SatMax : CoordW'(q);
    end
    return r;
  endfunction

  assign en = !out_vld_q || out_ready_i;
  assign pop_ready_o = en;

  // stage 0 loads operands; then one restoring division step per stage,
  // both coordinates side by side
  always_comb begin
    logic [DenW:0] tx, ty;
    st_d[0].culled   = pop_data_i.culled;
    st_d[0].zero_den = pop_data_i.zero_den;
    st_d[0].x_pos    = pop_data_i.x_pos;
    st_d[0].x_neg    = pop_data_i.x_neg;
    st_d[0].y_pos    = pop_data_i.y_pos;
    st_d[0].y_neg    = pop_data_i.y_neg;
    st_d[0].neg_x    = pop_data_i.neg_x;
    st_d[0].neg_y    = pop_data_i.neg_y;
    st_d[0].ad       = pop_data_i.ad;
    // quotient must fit 32 bits: high part of dividend below divisor
    st_d[0].ovf_x    = DenW'(pop_data_i.ax[NumW-1:CoordW]) >= pop_data_i.ad;
    st_d[0].ovf_y    = DenW'(pop_data_i.ay[NumW-1:CoordW]) >= pop_data_i.ad;
    st_d[0].rx       = DenW'(pop_data_i.ax[NumW-1:CoordW]);
    st_d[0].ry       = DenW'(pop_data_i.ay[NumW-1:CoordW]);
    st_d[0].lx       = pop_data_i.ax[CoordW-1:0];
    st_d[0].ly       = pop_data_i.ay[CoordW-1:0];
    st_d[0].qx       = '0;
    st_d[0].qy       = '0;
    for (int k = 0; k < DivSteps; k++) begin
      tx = {st_q[k].rx, st_q[k].lx[CoordW-1]};
      ty = {st_q[k].ry, st_q[k].ly[CoordW-1]};
      st_d[k+1] = st_q[k];
      st_d[k+1].lx = {st_q[k].lx[CoordW-2:0], 1'b0};
      st_d[k+1].ly = {st_q[k].ly[CoordW-2:0], 1'b0};
      if (tx >= {1'b0, st_q[k].ad}) begin
        st_d[k+1].rx = DenW'(tx - {1'b0, st_q[k].ad});
        st_d[k+1].qx = {st_q[k].qx[CoordW-2:0], 1'b1};
      end else begin
        st_d[k+1].rx = DenW'(tx);
        st_d[k+1].qx = {st_q[k].qx[CoordW-2:0], 1'b0};
      end
      if (ty >= {1'b0, st_q[k].ad}) begin
        st_d[k+1].ry = DenW'(ty - {1'b0, st_q[k].ad});
        st_d[k+1].qy = {st_q[k].qy[CoordW-2:0], 1'b1};
      end else begin
        st_d[k+1].ry = DenW'(ty);
        st_d[k+1].qy = {st_q[k].qy[CoordW-2:0], 1'b0};
      end
    end
  end

  assign fin = st_q[DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivSteps; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= pop_valid_i;
      for (int k = 1; k <= DivSteps; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= DivSteps; k++) begin
        st_q[k] <= st_d[k];
      end
      if (fin.culled) begin
        sx_q <= CullValue;
        sy_q <= CullValue;
      end else begin
        sx_q <= resolve(fin.qx, fin.neg_x, fin.ovf_x, fin.zero_den, fin.x_pos, fin.x_neg);
        sy_q <= resolve(fin.qy, fin.neg_y, fin.ovf_y, fin.zero_den, fin.y_pos, fin.y_neg);
      end
      cull_q <= fin.culled;
    end
  end

  assign out_valid_o = out_vld_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign culled_o    = cull_q;

endmodule

@@ hdl/world_to_screen_projection_top.sv @@
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   point_x_i, point_y_i, point_z_i
// out      output     out_valid_o / out_ready_i screen_x_o, screen_y_o, culled_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle while out_ready_i does not stall the output; the path runs through
// 6 front stages, the queue, a 32-stage one-bit-per-stage divider with a range
// check stage and the output register.
// Reset clears config to identity rotation at the origin and empties all stages.
// A stalled output freezes the back end; the queue then fills and the front
// stalls, so in_ready_o drops only when the queue is full.
module world_to_screen_projection_top import wtsp_pkg::*; #(
  parameter int FifoDepth = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoordW-1:0] screen_x_o,
  output logic signed [CoordW-1:0] screen_y_o,
  output logic                     culled_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i
);

  cfg_t  cfg_q;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  proj_t push_data, pop_data;

  // config writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cam_x     <= '0;
      cfg_q.cam_y     <= '0;
      cfg_q.cam_z     <= '0;
      cfg_q.cos_yaw   <= 16'sd16384;
      cfg_q.sin_yaw   <= '0;
      cfg_q.cos_pitch <= 16'sd16384;
      cfg_q.sin_pitch <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CAM_X:     cfg_q.cam_x     <= cfg_data_i;
        CFG_CAM_Y:     cfg_q.cam_y     <= cfg_data_i;
        CFG_CAM_Z:     cfg_q.cam_z     <= cfg_data_i;
        CFG_COS_YAW:   cfg_q.cos_yaw   <= cfg_data_i[TrigW-1:0];
        CFG_SIN_YAW:   cfg_q.sin_yaw   <= cfg_data_i[TrigW-1:0];
        CFG_COS_PITCH: cfg_q.cos_pitch <= cfg_data_i[TrigW-1:0];
        CFG_SIN_PITCH: cfg_q.sin_pitch <= cfg_data_i[TrigW-1:0];
        default: ;
      endcase
    end
  end

  // front: offset, yaw, pitch, near test and divider operand setup
  wtsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  wtsp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // back: rounded divide of both coordinates, saturation, cull override
  wtsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o),
    .culled_o    (culled_o)
  );

endmodule

@@ test/world_to_screen_projection_top_test.sv @@
module world_to_screen_projection_top_test;
  import wtsp_pkg::*;

  // Clock, reset and ports of the projection block
  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [CoordW-1:0] point_x_i;
  logic signed [CoordW-1:0] point_y_i;
  logic signed [CoordW-1:0] point_z_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [CoordW-1:0] screen_x_o;
  logic signed [CoordW-1:0] screen_y_o;
  logic                     culled_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [CfgDataW-1:0]      cfg_data_i;

  world_to_screen_projection_top dut (.*);

  // One projected vertex as the output port carries it
  typedef struct {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic                     culled;
  } screen_pt_t;

  // One row of the directed table; has_exp marks a hand-typed expectation
  typedef struct {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    bit                       has_exp;
    screen_pt_t               exp_pt;
  } vertex_row_t;

  localparam int WatchLimit = 5000;  // cycles with no handshake at all
  localparam int DrainWait  = 60;    // longer than the pipeline takes to empty

  // Shadow copy of the camera registers
  longint cam_x, cam_y, cam_z;
  longint cos_yaw, sin_yaw, cos_pitch, sin_pitch;

  screen_pt_t pending_pts[$];
  int         n_fail;
  int         n_items;
  int         n_results;
  int         n_culled;
  int         n_cfg;
  int         idle_pct;    // sender gap probability, percent
  int         stall_pct;   // receiver stall probability, percent
  int         quiet_cycles;

  // Clock: period 20
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Q.30 sum to Q16.16, round half up
  function automatic longint round_q30(longint s);
    return (s + RoundBias) >>> 14;
  endfunction

  // (c + z) / 2z in Q16.16, nearest with ties away from zero, saturated
  function automatic logic signed [CoordW-1:0] screen_coord(longint c, longint z);
    longint num, den, an, ad, q;
    if (z == 0) begin
      if (c > 0) return SatMax;
      if (c < 0) return SatMin;
      return HalfValue;
    end
    num = (c + z) * 65536;
    den = 2 * z;
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    q   = (an + ad / 2) / ad;
    if ((num < 0) != (den < 0)) q = -q;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  // Translate, yaw about Y, pitch about X, near cull, project
  function automatic screen_pt_t project_vertex(logic signed [CoordW-1:0] px,
                                                logic signed [CoordW-1:0] py,
                                                logic signed [CoordW-1:0] pz);
    screen_pt_t r;
    longint dx, dy, dz, x, z1, y, z;
    dx = longint'(px) - cam_x;
    dy = longint'(py) - cam_y;
    dz = longint'(pz) - cam_z;
    x  = round_q30(dx * cos_yaw + dz * sin_yaw);
    z1 = round_q30(dz * cos_yaw - dx * sin_yaw);
    y  = round_q30(dy * cos_pitch - z1 * sin_pitch);
    z  = round_q30(dy * sin_pitch + z1 * cos_pitch);
    if (z > NearLimit) begin
      r.sx = CullValue;
      r.sy = CullValue;
      r.culled = 1'b1;
    end else begin
      r.sx = screen_coord(x, z);
      r.sy = screen_coord(y, z);
      r.culled = 1'b0;
    end
    return r;
  endfunction

  function automatic bit coin(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Wait until every projected vertex has come back, then let the pipe settle
  task automatic drain();
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Register write; only called with the block idle. Valid stays high so that
  // writes can follow back to back; the caller drops it after the last one.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_cfg++;
    case (idx)
      CFG_CAM_X:     cam_x     = longint'(signed'(data));
      CFG_CAM_Y:     cam_y     = longint'(signed'(data));
      CFG_CAM_Z:     cam_z     = longint'(signed'(data));
      CFG_COS_YAW:   cos_yaw   = longint'(signed'(data[TrigW-1:0]));
      CFG_SIN_YAW:   sin_yaw   = longint'(signed'(data[TrigW-1:0]));
      CFG_COS_PITCH: cos_pitch = longint'(signed'(data[TrigW-1:0]));
      CFG_SIN_PITCH: sin_pitch = longint'(signed'(data[TrigW-1:0]));
      default: ;  // unmapped index: ignored by the block
    endcase
  endtask

  // Camera setups: 0 moderate random, 1 extremes, 2 full random bits
  task automatic load_camera(int kind);
    logic [CfgDataW-1:0] v[7];
    for (int i = 0; i < 7; i++) begin
      case (kind)
        0: v[i] = (i < 3) ? $urandom_range(2**21, 0) - 2**20
                          : $urandom_range(32768, 0) - 16384;
        1: v[i] = (i < 3) ? (coin(50) ? 32'h7fffffff : 32'h80000000)
                          : (coin(50) ? 32'sd16384 : -32'sd16384);
        default: v[i] = $urandom();
      endcase
    end
    write_reg(CFG_CAM_X, v[0]);
    write_reg(CFG_CAM_Y, v[1]);
    write_reg(CFG_CAM_Z, v[2]);
    write_reg(CFG_COS_YAW, v[3]);
    write_reg(CFG_SIN_YAW, v[4]);
    write_reg(CFG_COS_PITCH, v[5]);
    write_reg(CFG_SIN_PITCH, v[6]);
    // an index past the list must leave everything as it is
    write_reg(3'd7, $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one vertex, hold it until taken, log what should come back.
  // Valid is only dropped when a gap follows, so it never toggles in one step.
  task automatic send_vertex(logic signed [CoordW-1:0] px, logic signed [CoordW-1:0] py,
                             logic signed [CoordW-1:0] pz, bit has_exp,
                             screen_pt_t exp_pt);
    if (coin(idle_pct)) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (coin(idle_pct));
    end
    in_valid_i <= 1'b1;
    point_x_i  <= px;
    point_y_i  <= py;
    point_z_i  <= pz;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pts.push_back(has_exp ? exp_pt : project_vertex(px, py, pz));
    n_items++;
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random vertex: mostly near the camera so that the projection path is
  // exercised, the rest spread over the full 32-bit range
  task automatic send_random();
    screen_pt_t none;
    logic signed [CoordW-1:0] px, py, pz;
    none = '{default: '0};
    if (coin(60)) begin
      px = CoordW'(cam_x + $signed($urandom_range(2**22, 0)) - 2**21);
      py = CoordW'(cam_y + $signed($urandom_range(2**22, 0)) - 2**21);
      pz = CoordW'(cam_z - $signed($urandom_range(2**22, 0)) + 2**18);
    end else begin
      px = $urandom();
      py = $urandom();
      pz = $urandom();
    end
    send_vertex(px, py, pz, 1'b0, none);
  endtask

  // Result checker and receiver stall generator
  always @(posedge clk_i) begin
    screen_pt_t e;
    if (rst_ni) begin
      out_ready_i <= !coin(stall_pct);
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (culled_o) n_culled++;
        if (pending_pts.size() == 0) begin
          $error("result with nothing expected: x=%0d y=%0d culled=%0b",
                 screen_x_o, screen_y_o, culled_o);
          n_fail++;
        end else begin
          e = pending_pts.pop_front();
          if (screen_x_o !== e.sx) begin
            $error("screen_x: expected %0d, got %0d", e.sx, screen_x_o);
            n_fail++;
          end
          if (screen_y_o !== e.sy) begin
            $error("screen_y: expected %0d, got %0d", e.sy, screen_y_o);
            n_fail++;
          end
          if (culled_o !== e.culled) begin
            $error("culled: expected %0b, got %0b", e.culled, culled_o);
            n_fail++;
          end
        end
      end
    end else begin
      out_ready_i <= 1'b0;
    end
  end

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    vertex_row_t vertex_rows[$];
    screen_pt_t  none;
    screen_pt_t  cull_pt;
    none    = '{default: '0};
    cull_pt = '{CullValue, CullValue, 1'b1};

    // Reset: identity rotation, camera at origin
    cam_x = 0; cam_y = 0; cam_z = 0;
    cos_yaw = 16384; sin_yaw = 0; cos_pitch = 16384; sin_pitch = 0;
    n_items = 0; n_cfg = 0;
    idle_pct = 0; stall_pct = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    point_x_i   = '0;
    point_y_i   = '0;
    point_z_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings. Typed rows: zero depth gives 0.5 for a
    // zero coordinate and saturates otherwise; z just past the near limit culls;
    // z exactly at the limit still projects.
    vertex_rows = '{
      '{32'sd0, 32'sd0, 32'sd0, 1'b1, '{HalfValue, HalfValue, 1'b0}},
      '{32'sd65536, -32'sd65536, 32'sd0, 1'b1, '{SatMax, SatMin, 1'b0}},
      '{-32'sd1, 32'sd1, 32'sd0, 1'b1, '{SatMin, SatMax, 1'b0}},
      '{32'sd0, 32'sd0, 32'sd65536, 1'b1, cull_pt},
      '{32'sd0, 32'sd0, 32'sd3277, 1'b1, cull_pt},
      '{32'sd0, 32'sd0, 32'sd3276, 1'b1, '{HalfValue, HalfValue, 1'b0}},
      '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1, cull_pt},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, none},
      '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b0, none},
      '{32'sh80000000, 32'sh7fffffff, -32'sd1, 1'b0, none},
      '{32'sd65536, 32'sd65536, -32'sd65536, 1'b0, none},
      '{-32'sd32768, 32'sd32768, -32'sd65536, 1'b0, none},
      '{32'sd3, 32'sd1, -32'sd2, 1'b0, none},
      '{32'sd0, 32'sd0, -32'sd1, 1'b0, none},
      '{32'sh7fffffff, 32'sd0, -32'sd1, 1'b0, none}
    };
    foreach (vertex_rows[i])
      send_vertex(vertex_rows[i].px, vertex_rows[i].py, vertex_rows[i].pz,
                  vertex_rows[i].has_exp, vertex_rows[i].exp_pt);
    stop_sending();
    drain();

    // Extreme camera with the same corner points, predicted
    load_camera(1);
    foreach (vertex_rows[i])
      send_vertex(vertex_rows[i].px, vertex_rows[i].py, vertex_rows[i].pz, 1'b0, none);
    stop_sending();
    drain();

    // Random phases, one idling pattern each, fresh camera per quarter phase
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        load_camera((phase + blk) % 3);
        repeat (62) send_random();
        stop_sending();
        drain();
      end
    end

    $display("projected %0d vertices (%0d culled) over %0d register writes,",
             n_results, n_culled, n_cfg);
    $display("with sender gaps and receiver stalls mixed in per phase");
    if (n_fail == 0 && pending_pts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
